@@ rtl/stlf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_pkg: shared types and constants for the synced traffic light
// Phase coding, item kinds, register map, reset values and divide constants.
// ----------------------------------------------------------------------------
package stlf_pkg;

  localparam int ELAPSED_BITS  = 20;
  localparam int MS_PER_SECOND = 1000;
  localparam int REM_W         = 12;
  localparam int BLINK_W       = 10;
  localparam int DUR_W         = 16;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W  = 8;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 24;

  // divide by MS_PER_SECOND: q = (m * RECIP) >> RECIP_SHIFT, exact for m < 2**ELAPSED_BITS
  localparam int RECIP_SHIFT = ELAPSED_BITS + 10;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_GREEN   = 2'd0,
    PH_AMBER   = 2'd1,
    PH_RED     = 2'd2,
    PH_REDWAIT = 2'd3
  } phase_e;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MSG   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [2:0] REG_MASTER_MODE = 3'd0;
  localparam logic [2:0] REG_GROUP_SEL   = 3'd1;
  localparam logic [2:0] REG_GREEN_MS    = 3'd2;
  localparam logic [2:0] REG_AMBER_MS    = 3'd3;
  localparam logic [2:0] REG_RED_MS      = 3'd4;
  localparam logic [2:0] REG_BLINK_MS    = 3'd5;

  localparam logic [DUR_W-1:0]   GREEN_MS_RST = 16'd20000;
  localparam logic [DUR_W-1:0]   AMBER_MS_RST = 16'd5000;
  localparam logic [DUR_W-1:0]   RED_MS_RST   = 16'd20000;
  localparam logic [BLINK_W-1:0] BLINK_MS_RST = 10'd150;

  typedef struct packed {
    logic               master_mode;
    logic               group_sel;
    logic [DUR_W-1:0]   green_ms;
    logic [DUR_W-1:0]   amber_ms;
    logic [DUR_W-1:0]   red_ms;
    logic [BLINK_W-1:0] blink_ms;
  } cfg_t;

  // low bits first in tdata: remote_group, remote_master, remote_state
  typedef struct packed {
    logic [1:0] remote_state;
    logic       remote_master;
    logic       remote_group;
  } msg_t;

  typedef struct packed {
    logic [1:0] func;
    msg_t       msg;
  } item_t;

  typedef struct packed {
    logic signed [ELAPSED_BITS:0] diff;
    logic                         green_on;
    logic                         amber_on;
    logic                         red_on;
    phase_e                       light_state;
  } mid_t;

  // low bits first in tdata: light_state, red_on, amber_on, green_on, remaining_s
  typedef struct packed {
    logic signed [REM_W-1:0] remaining_s;
    logic                    green_on;
    logic                    amber_on;
    logic                    red_on;
    phase_e                  light_state;
  } res_t;

  function automatic phase_e slave_opposite(input logic [1:0] s);
    phase_e r;
    case (s)
      2'd0:    r = PH_RED;
      2'd1:    r = PH_RED;
      2'd2:    r = PH_GREEN;
      default: r = PH_AMBER;
    endcase
    return r;
  endfunction

  function automatic phase_e master_opposite(input logic [1:0] s);
    phase_e r;
    case (s)
      2'd0:    r = PH_RED;
      2'd1:    r = PH_AMBER;
      2'd2:    r = PH_GREEN;
      default: r = PH_AMBER;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/synced_traffic_light_fsm_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synced_traffic_light_fsm_top: four-phase traffic light with peer sync
//
// Input stream: one word per event; tuser carries the kind (1 ms tick, peer
// status message, start), tdata the peer fields. Output stream: one word per
// input word with the phase, the red/amber/green lamp drives and the signed
// seconds left in the phase.
// Path: input register, then the phase update into the mid register, then
// the seconds divide into the result register. Throughput: one word per
// cycle unless the output stalls; phase state feeds back through its own
// register. A stalled output holds its word; the two internal stages keep
// filling and s_axis_tready drops only when all stages hold data.
// Reset: phase red, timer and blink divider cleared, amber lamp off, all
// registers back to their reset values, pipeline empty.
// Configuration through the APB port while the stream is idle.
// ----------------------------------------------------------------------------
module synced_traffic_light_fsm_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stlf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [stlf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [stlf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // input words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] remote_group, [1] remote_master, [3:2] remote_state, [7:4] zero
  input  logic [stlf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [stlf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] light_state, [2] red_on, [3] amber_on, [4] green_on,
  // [16:5] remaining_s, [23:17] zero
  output logic [stlf_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  stlf_pkg::cfg_t  cfg;
  stlf_pkg::item_t item;
  stlf_pkg::mid_t  mid;
  stlf_pkg::res_t  res;
  logic            mid_valid, mid_ready;

  assign item.func = s_axis_tuser;
  assign item.msg  = s_axis_tdata[$bits(stlf_pkg::msg_t)-1:0];

  stlf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stlf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  stlf_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = stlf_pkg::M_TDATA_W'(res);

endmodule

@@ rtl/stlf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_cfg: configuration register file
// APB-style write and read of the six timing and role registers.
// ----------------------------------------------------------------------------
module stlf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stlf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [stlf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [stlf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output stlf_pkg::cfg_t                   cfg_o
);

  stlf_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        stlf_pkg::REG_MASTER_MODE: cfg_d.master_mode = pwdata[0];
        stlf_pkg::REG_GROUP_SEL:   cfg_d.group_sel   = pwdata[0];
        stlf_pkg::REG_GREEN_MS:    cfg_d.green_ms    = pwdata[stlf_pkg::DUR_W-1:0];
        stlf_pkg::REG_AMBER_MS:    cfg_d.amber_ms    = pwdata[stlf_pkg::DUR_W-1:0];
        stlf_pkg::REG_RED_MS:      cfg_d.red_ms      = pwdata[stlf_pkg::DUR_W-1:0];
        stlf_pkg::REG_BLINK_MS:    cfg_d.blink_ms    = pwdata[stlf_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_mode <= 1'b0;
      cfg_q.group_sel   <= 1'b0;
      cfg_q.green_ms    <= stlf_pkg::GREEN_MS_RST;
      cfg_q.amber_ms    <= stlf_pkg::AMBER_MS_RST;
      cfg_q.red_ms      <= stlf_pkg::RED_MS_RST;
      cfg_q.blink_ms    <= stlf_pkg::BLINK_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      stlf_pkg::REG_MASTER_MODE: prdata = stlf_pkg::APB_DATA_W'(cfg_q.master_mode);
      stlf_pkg::REG_GROUP_SEL:   prdata = stlf_pkg::APB_DATA_W'(cfg_q.group_sel);
      stlf_pkg::REG_GREEN_MS:    prdata = stlf_pkg::APB_DATA_W'(cfg_q.green_ms);
      stlf_pkg::REG_AMBER_MS:    prdata = stlf_pkg::APB_DATA_W'(cfg_q.amber_ms);
      stlf_pkg::REG_RED_MS:      prdata = stlf_pkg::APB_DATA_W'(cfg_q.red_ms);
      stlf_pkg::REG_BLINK_MS:    prdata = stlf_pkg::APB_DATA_W'(cfg_q.blink_ms);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/stlf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_core: input register and phase state update
// One word per cycle, unless stalled, updates phase, timer and blink state;
// registers phase, lamp drives and signed time-left in ms for the divide stage.
// ----------------------------------------------------------------------------
module stlf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stlf_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stlf_pkg::item_t in_item_i,
  output logic           mid_valid_o,
  input  logic           mid_ready_i,
  output stlf_pkg::mid_t mid_o
);

  localparam int EW = stlf_pkg::ELAPSED_BITS;

  logic                          in_v_q;
  stlf_pkg::item_t               item_q;
  logic                          mid_v_q;
  stlf_pkg::mid_t                mid_q, mid_d;
  logic                          mid_load;

  stlf_pkg::phase_e              phase_q, phase_d, target;
  logic [EW-1:0]                 elapsed_q, elapsed_d, el_tick;
  logic [stlf_pkg::BLINK_W-1:0]  blink_q, blink_d, bc_inc;
  logic                          lit_q, lit_d;
  logic                          go, same;
  logic [stlf_pkg::DUR_W-1:0]    green_limit, dur;

  assign mid_load   = in_v_q && (!mid_v_q || mid_ready_i);
  assign in_ready_o = !in_v_q || mid_load;

  assign el_tick     = (elapsed_q == stlf_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + EW'(1);
  assign bc_inc      = blink_q + stlf_pkg::BLINK_W'(1);
  assign green_limit = (cfg_i.green_ms > cfg_i.amber_ms) ? cfg_i.green_ms - cfg_i.amber_ms : '0;
  assign same        = (item_q.msg.remote_group == cfg_i.group_sel);

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    blink_d   = blink_q;
    lit_d     = lit_q;
    go        = 1'b0;
    target    = phase_q;
    case (item_q.func)
      stlf_pkg::FUNC_TICK: begin
        elapsed_d = el_tick;
        if (phase_q == stlf_pkg::PH_AMBER) begin
          if (bc_inc >= cfg_i.blink_ms) begin
            blink_d = '0;
            lit_d   = ~lit_q;
          end else begin
            blink_d = bc_inc;
          end
        end
        if (cfg_i.master_mode) begin
          case (phase_q)
            stlf_pkg::PH_GREEN: begin
              target = stlf_pkg::PH_AMBER;
              go     = el_tick >= EW'(green_limit);
            end
            stlf_pkg::PH_AMBER: begin
              target = stlf_pkg::PH_RED;
              go     = el_tick >= EW'(cfg_i.amber_ms);
            end
            stlf_pkg::PH_RED: begin
              target = stlf_pkg::PH_REDWAIT;
              go     = el_tick >= EW'(cfg_i.red_ms);
            end
            default: begin
              target = stlf_pkg::PH_GREEN;
              go     = el_tick >= EW'(cfg_i.amber_ms);
            end
          endcase
        end
      end
      stlf_pkg::FUNC_MSG: begin
        if (item_q.msg.remote_master) begin
          if (!cfg_i.master_mode) begin
            go     = 1'b1;
            target = same ? stlf_pkg::phase_e'(item_q.msg.remote_state)
                          : stlf_pkg::slave_opposite(item_q.msg.remote_state);
          end else if (!same) begin
            go     = 1'b1;
            target = stlf_pkg::master_opposite(item_q.msg.remote_state);
          end
        end
      end
      stlf_pkg::FUNC_START: begin
        go     = 1'b1;
        target = cfg_i.group_sel ? stlf_pkg::PH_RED : stlf_pkg::PH_GREEN;
      end
      default: ;
    endcase
    // entering the current phase keeps timer and blink state
    if (go && (target != phase_q)) begin
      phase_d   = target;
      elapsed_d = '0;
      blink_d   = '0;
      lit_d     = 1'b0;
    end
  end

  always_comb begin
    case (phase_d)
      stlf_pkg::PH_GREEN: dur = cfg_i.green_ms;
      stlf_pkg::PH_RED:   dur = cfg_i.red_ms;
      default:            dur = cfg_i.amber_ms;
    endcase
    mid_d.light_state = phase_d;
    mid_d.red_on      = (phase_d == stlf_pkg::PH_RED) || (phase_d == stlf_pkg::PH_REDWAIT);
    mid_d.amber_on    = (phase_d == stlf_pkg::PH_AMBER) && lit_d;
    mid_d.green_on    = (phase_d == stlf_pkg::PH_GREEN);
    mid_d.diff        = $signed({1'b0, EW'(dur)}) - $signed({1'b0, elapsed_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      mid_v_q   <= 1'b0;
      phase_q   <= stlf_pkg::PH_RED;
      elapsed_q <= '0;
      blink_q   <= '0;
      lit_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (mid_load) begin
        mid_v_q   <= 1'b1;
        phase_q   <= phase_d;
        elapsed_q <= elapsed_d;
        blink_q   <= blink_d;
        lit_q     <= lit_d;
      end else if (mid_ready_i) begin
        mid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (mid_load) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_v_q;
  assign mid_o       = mid_q;

endmodule

@@ rtl/stlf_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_rem: seconds-left divide and result register
// Signed ms difference to seconds, truncated toward zero, by reciprocal
// multiply on the magnitude; holds the result word for the output channel.
// ----------------------------------------------------------------------------
module stlf_rem (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mid_valid_i,
  output logic           mid_ready_o,
  input  stlf_pkg::mid_t mid_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stlf_pkg::res_t out_o
);

  localparam int EW    = stlf_pkg::ELAPSED_BITS;
  localparam int PW    = EW + stlf_pkg::RECIP_W;
  localparam int RW    = stlf_pkg::REM_W;

  logic                out_v_q;
  stlf_pkg::res_t      out_q, out_d;
  logic                neg;
  logic [EW-1:0]       mag;
  logic [PW-1:0]       prod;
  logic [RW-1:0]       quo;

  assign mid_ready_o = !out_v_q || out_ready_i;

  assign neg  = mid_i.diff[EW];
  assign mag  = EW'(neg ? -mid_i.diff : mid_i.diff);
  assign prod = PW'(mag) * PW'(stlf_pkg::RECIP);
  assign quo  = prod[stlf_pkg::RECIP_SHIFT +: RW];

  always_comb begin
    out_d.light_state = mid_i.light_state;
    out_d.red_on      = mid_i.red_on;
    out_d.amber_on    = mid_i.amber_on;
    out_d.green_on    = mid_i.green_on;
    out_d.remaining_s = neg ? $signed(-quo) : $signed(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_v_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready_o && mid_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

@@ rtl/stlf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_checker: port-level checks for the traffic light top
// Output hold under stall, lamp decode, and ready when the output is empty.
// ----------------------------------------------------------------------------
module stlf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [stlf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] ls;
  assign ls = m_axis_tdata[1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == ((ls == stlf_pkg::PH_RED) ||
                                           (ls == stlf_pkg::PH_REDWAIT)))
                   && (m_axis_tdata[4] == (ls == stlf_pkg::PH_GREEN))
                   && (!m_axis_tdata[3] || (ls == stlf_pkg::PH_AMBER)))
    else $error("lamp drives do not match phase");

  // empty output register means both internal stages can drain
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  a_no_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tvalid |=> s_axis_tready || m_axis_tvalid)
    else $error("pipeline blocked without output");

endmodule

bind synced_traffic_light_fsm_top stlf_checker u_stlf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the synced traffic light
// Streams ticks, peer messages and start words into the block and keeps an
// in-bench phase model that predicts every result word: phase, lamp drives
// and seconds left. Covers directed phase walks, slave and master sync rules,
// register read-back, back-pressure and random traffic under several
// register settings.
// ----------------------------------------------------------------------------
module tb;
  import stlf_pkg::*;

  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [0] remote_group, [1] remote_master, [3:2] remote_state, [7:4] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  // [1:0] func
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [1:0] light_state, [2] red_on, [3] amber_on, [4] green_on, [16:5] remaining_s
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  synced_traffic_light_fsm_top u_top (.*);

  // phase model state
  cfg_t                    light_cfg;
  phase_e                  light_ph;
  logic [ELAPSED_BITS-1:0] light_elapsed;
  logic [BLINK_W-1:0]      light_blink;
  logic                    light_lit;

  res_t lamp_q[$];
  int   mismatches;
  bit   src_idle;
  bit   sink_idle;
  int   sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  function automatic msg_t peer_msg(input logic grp, input logic mst, input logic [1:0] st);
    msg_t m;
    m.remote_group  = grp;
    m.remote_master = mst;
    m.remote_state  = st;
    return m;
  endfunction

  function automatic void light_enter(input phase_e p);
    if (p != light_ph) begin
      light_ph      = p;
      light_elapsed = '0;
      light_blink   = '0;
      light_lit     = 1'b0;
    end
  endfunction

  // sender phase seen from the other group; only a slave turns amber into red
  function automatic phase_e cross_phase(input phase_e s, input logic as_master);
    case (s)
      PH_GREEN: return PH_RED;
      PH_AMBER: return as_master ? PH_AMBER : PH_RED;
      PH_RED:   return PH_GREEN;
      default:  return PH_AMBER;
    endcase
  endfunction

  function automatic res_t step_light(input logic [1:0] func, input msg_t m);
    logic [DUR_W-1:0] lim;
    longint           secs;
    longint           el;
    res_t             r;
    case (func)
      FUNC_TICK: begin
        if (light_elapsed != ELAPSED_MAX) light_elapsed = light_elapsed + ELAPSED_BITS'(1);
        if (light_ph == PH_AMBER) begin
          light_blink = light_blink + BLINK_W'(1);
          if (light_blink >= light_cfg.blink_ms) begin
            light_blink = '0;
            light_lit   = ~light_lit;
          end
        end
        if (light_cfg.master_mode) begin
          case (light_ph)
            PH_GREEN: begin
              // green hands over early by the amber time
              lim = (light_cfg.green_ms > light_cfg.amber_ms) ?
                    light_cfg.green_ms - light_cfg.amber_ms : '0;
              if (light_elapsed >= ELAPSED_BITS'(lim)) light_enter(PH_AMBER);
            end
            PH_AMBER:
              if (light_elapsed >= ELAPSED_BITS'(light_cfg.amber_ms)) light_enter(PH_RED);
            PH_RED:
              if (light_elapsed >= ELAPSED_BITS'(light_cfg.red_ms)) light_enter(PH_REDWAIT);
            default:
              if (light_elapsed >= ELAPSED_BITS'(light_cfg.amber_ms)) light_enter(PH_GREEN);
          endcase
        end
      end
      FUNC_MSG: begin
        if (m.remote_master) begin
          if (!light_cfg.master_mode) begin
            if (m.remote_group == light_cfg.group_sel)
              light_enter(phase_e'(m.remote_state));
            else
              light_enter(cross_phase(phase_e'(m.remote_state), 1'b0));
          end else if (m.remote_group != light_cfg.group_sel) begin
            light_enter(cross_phase(phase_e'(m.remote_state), 1'b1));
          end
        end
      end
      FUNC_START: light_enter(light_cfg.group_sel ? PH_RED : PH_GREEN);
      default: ;
    endcase
    case (light_ph)
      PH_GREEN: secs = longint'(light_cfg.green_ms);
      PH_RED:   secs = longint'(light_cfg.red_ms);
      default:  secs = longint'(light_cfg.amber_ms);
    endcase
    el   = longint'(light_elapsed);
    secs = (secs - el) / MS_PER_SECOND;
    r.light_state = light_ph;
    r.red_on      = (light_ph == PH_RED) || (light_ph == PH_REDWAIT);
    r.amber_on    = (light_ph == PH_AMBER) && light_lit;
    r.green_on    = (light_ph == PH_GREEN);
    r.remaining_s = secs[REM_W-1:0];
    return r;
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_MASTER_MODE: return APB_DATA_W'(light_cfg.master_mode);
      REG_GROUP_SEL:   return APB_DATA_W'(light_cfg.group_sel);
      REG_GREEN_MS:    return APB_DATA_W'(light_cfg.green_ms);
      REG_AMBER_MS:    return APB_DATA_W'(light_cfg.amber_ms);
      REG_RED_MS:      return APB_DATA_W'(light_cfg.red_ms);
      default:         return APB_DATA_W'(light_cfg.blink_ms);
    endcase
  endfunction

  task automatic reg_check(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== reg_value(idx))
      note_mismatch($sformatf("register %0d", idx), reg_value(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_MASTER_MODE: light_cfg.master_mode = val[0];
      REG_GROUP_SEL:   light_cfg.group_sel   = val[0];
      REG_GREEN_MS:    light_cfg.green_ms    = val[DUR_W-1:0];
      REG_AMBER_MS:    light_cfg.amber_ms    = val[DUR_W-1:0];
      REG_RED_MS:      light_cfg.red_ms      = val[DUR_W-1:0];
      REG_BLINK_MS:    light_cfg.blink_ms    = val[BLINK_W-1:0];
      default: ;
    endcase
    if (idx <= REG_BLINK_MS) begin
      reg_check(idx);
    end else begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_word(input logic [1:0] func, input msg_t m);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(S_TDATA_W - $bits(msg_t)){1'b0}}, m};
    do @(posedge clk_i); while (!s_axis_tready);
    lamp_q.push_back(step_light(func, m));
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int         r;
    logic [1:0] f;
    msg_t       m;
    r = $urandom_range(0, 99);
    f = (r < 55) ? FUNC_TICK : (r < 85) ? FUNC_MSG : (r < 97) ? FUNC_START : FUNC_SPARE;
    m = 4'($urandom);
    // mostly master senders so messages actually move the phase
    if (f == FUNC_MSG && $urandom_range(0, 4) != 0) m.remote_master = 1'b1;
    send_word(f, m);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DUR_W'($urandom);
      default: return DUR_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [BLINK_W-1:0] pick_blink();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BLINK_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_config();
    reg_write(REG_MASTER_MODE, $urandom);
    reg_write(REG_GROUP_SEL, $urandom);
    reg_write(REG_GREEN_MS, {16'($urandom), pick_duration()});
    reg_write(REG_AMBER_MS, {16'($urandom), pick_duration()});
    reg_write(REG_RED_MS, {16'($urandom), pick_duration()});
    reg_write(REG_BLINK_MS, {22'($urandom), pick_blink()});
    if ($urandom_range(0, 3) == 0) reg_write(REG_SPARE_LO, $urandom);
  endtask

  // ---- tests ----

  task automatic test_reset_state();
    for (int i = 0; i <= REG_BLINK_MS; i++) reg_check(i[2:0]);
    send_word(FUNC_TICK, '0);
    send_word(FUNC_SPARE, 4'hF);
    send_word(FUNC_MSG, peer_msg(1'b0, 1'b0, PH_GREEN));
    send_word(FUNC_MSG, peer_msg(1'b1, 1'b1, PH_RED));
    send_word(FUNC_START, '0);
    wait_drained();
  endtask

  task automatic test_slave_follow();
    for (int st = 0; st < 4; st++) send_word(FUNC_MSG, peer_msg(1'b0, 1'b1, st[1:0]));
    for (int st = 0; st < 4; st++) send_word(FUNC_MSG, peer_msg(1'b1, 1'b1, st[1:0]));
    // re-entering the current phase keeps the timer
    send_word(FUNC_TICK, '0);
    send_word(FUNC_TICK, '0);
    send_word(FUNC_MSG, peer_msg(light_cfg.group_sel, 1'b1, light_ph));
    wait_drained();
  endtask

  task automatic test_master_cycle();
    reg_write(REG_MASTER_MODE, 32'd1);
    reg_write(REG_GREEN_MS, 32'd3);
    reg_write(REG_AMBER_MS, 32'd2);
    reg_write(REG_RED_MS, 32'd4);
    reg_write(REG_BLINK_MS, 32'd1);
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0000_0001);
    send_word(FUNC_START, '0);
    repeat (10) send_word(FUNC_TICK, '0);
    for (int st = 0; st < 4; st++) send_word(FUNC_MSG, peer_msg(1'b1, 1'b1, st[1:0]));
    send_word(FUNC_MSG, peer_msg(1'b0, 1'b1, PH_RED));
    send_word(FUNC_MSG, peer_msg(1'b1, 1'b0, PH_RED));
    wait_drained();
    // amber longer than green: green ends on the first tick; blink on every tick
    reg_write(REG_GREEN_MS, 32'd1);
    reg_write(REG_AMBER_MS, 32'd5);
    reg_write(REG_BLINK_MS, 32'd0);
    send_word(FUNC_MSG, peer_msg(1'b1, 1'b1, PH_RED));
    repeat (6) send_word(FUNC_TICK, '0);
    wait_drained();
    reg_write(REG_GREEN_MS, 32'd0);
    reg_write(REG_AMBER_MS, 32'd0);
    reg_write(REG_RED_MS, 32'd0);
    repeat (3) send_word(FUNC_TICK, '0);
    wait_drained();
    reg_write(REG_GROUP_SEL, 32'd1);
    send_word(FUNC_START, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    random_config();
    reg_write(REG_MASTER_MODE, 32'd1);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = 80;
    repeat (40) send_random();
    repeat (20) send_random();
    wait_drained();
    repeat (20) send_random();
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      random_config();
      src_idle  = ($urandom_range(0, 2) != 0);
      sink_idle = ($urandom_range(0, 2) != 0);
      repeat (100) send_random();
      wait_drained();
    end
  endtask

  task automatic test_final_burst();
    random_config();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (200) send_random();
    wait_drained();
  endtask

  // ---- result sink with random stalls and the long hold ----
  initial begin : sink
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin : check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(res_t)-1:0];
      if (lamp_q.size() == 0) begin
        mismatches++;
        $error("result word %0h with no prediction pending", m_axis_tdata);
      end else begin
        want = lamp_q.pop_front();
        if (got.light_state !== want.light_state)
          note_mismatch("light_state", want.light_state, got.light_state);
        if (got.red_on !== want.red_on) note_mismatch("red_on", want.red_on, got.red_on);
        if (got.amber_on !== want.amber_on)
          note_mismatch("amber_on", want.amber_on, got.amber_on);
        if (got.green_on !== want.green_on)
          note_mismatch("green_on", want.green_on, got.green_on);
        if (got.remaining_s !== want.remaining_s)
          note_mismatch("remaining_s", want.remaining_s, got.remaining_s);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    src_idle   = 1'b0;
    sink_idle  = 1'b0;
    sink_hold  = 0;
    mismatches = 0;
    light_cfg.master_mode = 1'b0;
    light_cfg.group_sel   = 1'b0;
    light_cfg.green_ms    = GREEN_MS_RST;
    light_cfg.amber_ms    = AMBER_MS_RST;
    light_cfg.red_ms      = RED_MS_RST;
    light_cfg.blink_ms    = BLINK_MS_RST;
    light_ph      = PH_RED;
    light_elapsed = '0;
    light_blink   = '0;
    light_lit     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_slave_follow();
    test_master_cycle();
    test_backpressure();
    test_random_phases();
    test_final_burst();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
